@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the escape-token parser checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is held.
`define METS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define METS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/mets_pkg.sv @@
// ----------------------------------------------------------------------------
// mets_pkg
// Types and constants shared by the macro escape-token parser.
// ----------------------------------------------------------------------------
package mets_pkg;

  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 3;
  localparam int DELAY_W = 14;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int IDX_W   = 3;

  // token kinds
  localparam logic [KIND_W-1:0] KIND_CHAR  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TAP   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DOWN  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_UP    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DELAY = 3'd4;
  localparam logic [KIND_W-1:0] KIND_OTHER = 3'd5;
  localparam logic [KIND_W-1:0] KIND_END   = 3'd6;
  localparam logic [KIND_W-1:0] KIND_ERROR = 3'd7;

  // register indexes (byte address = 4 * index)
  localparam logic [IDX_W-1:0] REG_PREFIX = 3'd0;
  localparam logic [IDX_W-1:0] REG_TAP    = 3'd1;
  localparam logic [IDX_W-1:0] REG_DOWN   = 3'd2;
  localparam logic [IDX_W-1:0] REG_UP     = 3'd3;
  localparam logic [IDX_W-1:0] REG_DELAY  = 3'd4;

  // register reset values
  localparam logic [BYTE_W-1:0] RST_PREFIX = 8'd1;
  localparam logic [BYTE_W-1:0] RST_TAP    = 8'd1;
  localparam logic [BYTE_W-1:0] RST_DOWN   = 8'd2;
  localparam logic [BYTE_W-1:0] RST_UP     = 8'd3;
  localparam logic [BYTE_W-1:0] RST_DELAY  = 8'd4;

  localparam logic [BYTE_W-1:0]  BAR_BYTE    = 8'h7C;  // '|'
  localparam logic [BYTE_W-1:0]  DIGIT_ZERO  = 8'h30;  // '0'
  localparam logic [BYTE_W-1:0]  DIGIT_NINE  = 8'h39;  // '9'
  localparam logic [DELAY_W-1:0] DELAY_LIMIT = 14'd9999;

  typedef struct packed {
    logic [BYTE_W-1:0] prefix_byte;
    logic [BYTE_W-1:0] tap_code;
    logic [BYTE_W-1:0] down_code;
    logic [BYTE_W-1:0] up_code;
    logic [BYTE_W-1:0] delay_code;
  } mets_cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0]  token_kind;
    logic [BYTE_W-1:0]  token_value;
    logic [DELAY_W-1:0] delay_ms;
  } mets_token_t;

endpackage

@@ hw/rtl/mets_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// mets_cfg_regs
// APB-style register bank holding the escape byte codes.
// ----------------------------------------------------------------------------
module mets_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mets_pkg::ADDR_W-1:0]  paddr,
  input  logic [mets_pkg::DATA_W-1:0]  pwdata,
  output logic [mets_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output mets_pkg::mets_cfg_t          cfg
);
  import mets_pkg::*;

  mets_cfg_t        cfg_r;
  logic             wr_en;
  logic [IDX_W-1:0] idx;
  logic [BYTE_W-1:0] rd_byte;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prefix_byte <= RST_PREFIX;
      cfg_r.tap_code    <= RST_TAP;
      cfg_r.down_code   <= RST_DOWN;
      cfg_r.up_code     <= RST_UP;
      cfg_r.delay_code  <= RST_DELAY;
    end else if (wr_en) begin
      unique case (idx)
        REG_PREFIX: cfg_r.prefix_byte <= pwdata[BYTE_W-1:0];
        REG_TAP:    cfg_r.tap_code    <= pwdata[BYTE_W-1:0];
        REG_DOWN:   cfg_r.down_code   <= pwdata[BYTE_W-1:0];
        REG_UP:     cfg_r.up_code     <= pwdata[BYTE_W-1:0];
        REG_DELAY:  cfg_r.delay_code  <= pwdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PREFIX: rd_byte = cfg_r.prefix_byte;
      REG_TAP:    rd_byte = cfg_r.tap_code;
      REG_DOWN:   rd_byte = cfg_r.down_code;
      REG_UP:     rd_byte = cfg_r.up_code;
      REG_DELAY:  rd_byte = cfg_r.delay_code;
      default:    rd_byte = '0;
    endcase
  end

  assign prdata = {{(DATA_W-BYTE_W){1'b0}}, rd_byte};
  assign cfg    = cfg_r;

endmodule

@@ hw/rtl/mets_parser.sv @@
// ----------------------------------------------------------------------------
// mets_parser
// Parse state and combinational next-state / token logic, one byte per beat.
// ----------------------------------------------------------------------------
module mets_parser #(
  parameter int MAX_DELAY_DIGITS = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [mets_pkg::BYTE_W-1:0] byte_in,
  input  mets_pkg::mets_cfg_t         cfg,
  output logic                        emit,
  output mets_pkg::mets_token_t       token
);
  import mets_pkg::*;

  localparam int SLOT_W = $clog2(MAX_DELAY_DIGITS + 1);
  localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(MAX_DELAY_DIGITS);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_PREFIX = 2'd1;
  localparam logic [1:0] PH_KEY    = 2'd2;
  localparam logic [1:0] PH_DELAY  = 2'd3;

  logic [1:0]         phase_r, phase_nxt;
  logic [BYTE_W-1:0]  held_r, held_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [DELAY_W-1:0] accum_r, accum_nxt;
  logic               stopped_r, stopped_nxt;

  logic               is_zero, is_digit;
  logic [17:0]        acc_sum;

  assign is_zero  = (byte_in == '0);
  assign is_digit = (byte_in >= DIGIT_ZERO) && (byte_in <= DIGIT_NINE);

  // accum * 10 + digit; digit is the low nibble of an ASCII digit
  assign acc_sum = {1'b0, accum_r, 3'b000} + {3'b000, accum_r, 1'b0}
                 + {14'd0, byte_in[3:0]};

  always_comb begin
    phase_nxt   = phase_r;
    held_nxt    = held_r;
    slot_nxt    = slot_r;
    accum_nxt   = accum_r;
    stopped_nxt = stopped_r;
    emit        = 1'b0;
    token       = '0;

    unique case (phase_r)
      PH_IDLE: begin
        priority if (is_zero) begin
          emit             = 1'b1;
          token.token_kind = KIND_END;
        end else if (byte_in == cfg.prefix_byte) begin
          phase_nxt = PH_PREFIX;
        end else begin
          emit              = 1'b1;
          token.token_kind  = KIND_CHAR;
          token.token_value = byte_in;
        end
      end

      PH_PREFIX: begin
        priority if (is_zero) begin
          phase_nxt        = PH_IDLE;
          emit             = 1'b1;
          token.token_kind = KIND_ERROR;
        end else if (byte_in == cfg.tap_code || byte_in == cfg.down_code ||
                     byte_in == cfg.up_code) begin
          held_nxt  = byte_in;
          phase_nxt = PH_KEY;
        end else if (byte_in == cfg.delay_code) begin
          phase_nxt   = PH_DELAY;
          slot_nxt    = '0;
          accum_nxt   = '0;
          stopped_nxt = 1'b0;
        end else begin
          phase_nxt         = PH_IDLE;
          emit              = 1'b1;
          token.token_kind  = KIND_OTHER;
          token.token_value = byte_in;
        end
      end

      PH_KEY: begin
        phase_nxt         = PH_IDLE;
        emit              = 1'b1;
        token.token_value = byte_in;
        // kind is decided against the registers as they stand now
        priority if (is_zero) begin
          token.token_kind  = KIND_ERROR;
          token.token_value = '0;
        end else if (held_r == cfg.tap_code) begin
          token.token_kind = KIND_TAP;
        end else if (held_r == cfg.down_code) begin
          token.token_kind = KIND_DOWN;
        end else if (held_r == cfg.up_code) begin
          token.token_kind = KIND_UP;
        end else begin
          token.token_kind  = KIND_ERROR;
          token.token_value = '0;
        end
      end

      PH_DELAY: begin
        priority if (is_zero) begin
          phase_nxt        = PH_IDLE;
          emit             = 1'b1;
          token.token_kind = KIND_ERROR;
        end else if (byte_in == BAR_BYTE) begin
          // a zero delay is dropped silently
          phase_nxt = PH_IDLE;
          if (accum_r != '0) begin
            emit             = 1'b1;
            token.token_kind = KIND_DELAY;
            token.delay_ms   = accum_r;
          end
        end else if (slot_r >= SLOT_MAX) begin
          phase_nxt        = PH_IDLE;
          emit             = 1'b1;
          token.token_kind = KIND_ERROR;
        end else begin
          slot_nxt = slot_r + 1'b1;
          if (!stopped_r) begin
            if (is_digit) begin
              accum_nxt = (acc_sum > {4'd0, DELAY_LIMIT}) ? DELAY_LIMIT
                                                           : acc_sum[DELAY_W-1:0];
            end else begin
              stopped_nxt = 1'b1;
            end
          end
        end
      end

      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      held_r    <= '0;
      slot_r    <= '0;
      accum_r   <= '0;
      stopped_r <= 1'b0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      held_r    <= held_nxt;
      slot_r    <= slot_nxt;
      accum_r   <= accum_nxt;
      stopped_r <= stopped_nxt;
    end
  end

endmodule

@@ hw/rtl/macro_escape_token_parser.sv @@
// Path: input register, parse logic, then token register driving out_*.
// Throughput: one byte per cycle while out_ready is high; the whole parse step
//   is one pass of logic between the input register and the token register.
// Reset: synchronous, active-low rst_n; parser returns to idle, both stages
//   empty, escape code registers reload their defaults.
// ----------------------------------------------------------------------------
// macro_escape_token_parser
// Turns a stream of stored macro string bytes into character, key, delay,
// pass-through escape, end and error tokens.
// ----------------------------------------------------------------------------
module macro_escape_token_parser #(
  parameter int MAX_DELAY_DIGITS = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input byte channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [mets_pkg::BYTE_W-1:0]  in_macro_byte,
  // token channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mets_pkg::KIND_W-1:0]  out_token_kind,
  output logic [mets_pkg::BYTE_W-1:0]  out_token_value,
  output logic [mets_pkg::DELAY_W-1:0] out_delay_ms,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mets_pkg::ADDR_W-1:0]  paddr,
  input  logic [mets_pkg::DATA_W-1:0]  pwdata,
  output logic [mets_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import mets_pkg::*;

  mets_cfg_t         cfg;
  mets_token_t       tok;
  mets_token_t       tok_r;
  logic              emit;

  logic              in_vld_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              out_vld_r;
  logic              advance;

  // Register bank for the escape codes.
  mets_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // A held byte moves through the parser when the token register is free
  // or is being drained this cycle. Bytes that make no token still need
  // the slot so that token order always follows byte order.
  assign advance  = in_vld_r & (~out_vld_r | out_ready);
  assign in_ready = ~in_vld_r | advance;

  // Input register: one byte beat deep.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_macro_byte;
    end
  end

  // Parse state and token logic; state steps only when the byte advances.
  mets_parser #(
    .MAX_DELAY_DIGITS (MAX_DELAY_DIGITS)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .byte_in (in_byte_r),
    .cfg     (cfg),
    .emit    (emit),
    .token   (tok)
  );

  // Token register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= emit;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      tok_r <= tok;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_token_kind  = tok_r.token_kind;
  assign out_token_value = tok_r.token_value;
  assign out_delay_ms    = tok_r.delay_ms;

endmodule

@@ hw/rtl/mets_checker.sv @@
// ----------------------------------------------------------------------------
// mets_checker
// Port-level checks on the token channel of the escape-token parser.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mets_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [mets_pkg::KIND_W-1:0]  out_token_kind,
  input logic [mets_pkg::BYTE_W-1:0]  out_token_value,
  input logic [mets_pkg::DELAY_W-1:0] out_delay_ms
);
  import mets_pkg::*;

  `METS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_token_kind) && $stable(out_token_value) && $stable(out_delay_ms), "token changed while stalled")

  `METS_ASSERT(a_delay_range, out_valid && out_token_kind == KIND_DELAY |-> out_delay_ms != '0 && out_delay_ms <= DELAY_LIMIT && out_token_value == '0, "bad delay token")

  `METS_ASSERT(a_no_stray_delay, out_valid && out_token_kind != KIND_DELAY |-> out_delay_ms == '0, "delay on non-delay token")

  `METS_ASSERT(a_empty_value, out_valid && (out_token_kind == KIND_END || out_token_kind == KIND_ERROR) |-> out_token_value == '0, "value on end or error token")

  `METS_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "token valid after reset")

endmodule

bind macro_escape_token_parser mets_checker u_mets_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_token_kind  (out_token_kind),
  .out_token_value (out_token_value),
  .out_delay_ms    (out_delay_ms)
);
